// ===== design/ptri_pkg.sv =====
// Package for the polygon triangle assembly block: field widths, internal
// widths and the triangle record type. No dependencies.
package ptri_pkg;

   // Port field widths, fixed by the interface
   localparam int VERTEX_FIELD_BITS = 32;
   localparam int TOTAL_FIELD_BITS  = 16;
   localparam int TRI_NUM_BITS      = 32;

   // Significant bits of the vertex index and of the corner count
   localparam int INDEX_BITS        = 32;
   localparam int CORNER_COUNT_BITS = 16;

   // Result queue: must hold two triangles beyond a full pipeline
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Hexagons use their own split
   localparam logic [CORNER_COUNT_BITS-1:0] HEX_SIZE = CORNER_COUNT_BITS'(6);

   typedef struct packed {
      logic [TRI_NUM_BITS-1:0]      triangle_number;
      logic [VERTEX_FIELD_BITS-1:0] corner_a;
      logic [VERTEX_FIELD_BITS-1:0] corner_b;
      logic [VERTEX_FIELD_BITS-1:0] corner_c;
      logic                         run_end;
   } tri_type;

endpackage

// ===== design/ptri_req_if.sv =====
// Request channel of the polygon triangle assembly block: one polygon corner.
// Depends on ptri_pkg.
interface ptri_req_if;
   import ptri_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [VERTEX_FIELD_BITS-1:0] vertex_index;
   logic [TOTAL_FIELD_BITS-1:0]  corner_total;
   logic                         mesh_start;

   modport source (output valid, vertex_index, corner_total, mesh_start, input ready);
   modport sink   (input valid, vertex_index, corner_total, mesh_start, output ready);
endinterface

// ===== design/ptri_rsp_if.sv =====
// Response channel of the polygon triangle assembly block: one triangle.
// Depends on ptri_pkg.
interface ptri_rsp_if;
   import ptri_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [TRI_NUM_BITS-1:0]      triangle_number;
   logic [VERTEX_FIELD_BITS-1:0] corner_a;
   logic [VERTEX_FIELD_BITS-1:0] corner_b;
   logic [VERTEX_FIELD_BITS-1:0] corner_c;
   logic                         run_end;

   modport source (output valid, triangle_number, corner_a, corner_b, corner_c, run_end,
                   input ready);
   modport sink   (input valid, triangle_number, corner_a, corner_b, corner_c, run_end,
                   output ready);
endinterface

// ===== design/polygon_triangle_assembly_core.sv =====
// Polygon triangle assembly: corners in, fan triangles (hexagon split) out.
// A triangle is written into the four-entry result queue when its corner is taken.
// Throughput: one corner per cycle while the queue has room for two triangles; a
// hexagon's last corner yields two, drained one per cycle while the sink is ready.
// Reset (synchronous, active high) clears polygon state, the counter and the queue.
// Depends on ptri_pkg, ptri_req_if and ptri_rsp_if.
module polygon_triangle_assembly_core (
   input  logic          clock,
   input  logic          reset,
   ptri_req_if.sink      req_chan,
   ptri_rsp_if.source    rsp_chan
);
   import ptri_pkg::*;

   logic [CORNER_COUNT_BITS-1:0] pos_ff, pos_in;
   logic [CORNER_COUNT_BITS-1:0] size_ff, size_in;
   logic [INDEX_BITS-1:0]        anchor_ff, anchor_in;
   logic [INDEX_BITS-1:0]        prev_ff, prev_in;
   logic [INDEX_BITS-1:0]        hex3_ff, hex3_in;
   logic [TRI_NUM_BITS-1:0]      count_ff, count_in;

   tri_type                      queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0]    fill_ff, fill_in;

   logic                         accept, pop;
   logic [INDEX_BITS-1:0]        vert;
   logic [CORNER_COUNT_BITS-1:0] total, pos, size, pos_inc;
   logic [INDEX_BITS-1:0]        anchor;
   logic [TRI_NUM_BITS-1:0]      count_base;
   logic                         is_hex, gen_first, gen_second;
   tri_type                      tri_first, tri_second;

   // Room for two triangles is needed before a corner is taken
   assign req_chan.ready = (fill_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));
   assign accept = req_chan.valid && req_chan.ready;
   assign pop    = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      vert       = req_chan.vertex_index[INDEX_BITS-1:0];
      total      = req_chan.corner_total[CORNER_COUNT_BITS-1:0];
      // a mesh start restarts the polygon and the numbering
      pos        = req_chan.mesh_start ? '0 : pos_ff;
      count_base = req_chan.mesh_start ? '0 : count_ff;
      size       = (pos == '0) ? total : size_ff;
      anchor     = (pos == '0) ? vert  : anchor_ff;
      is_hex     = (size == HEX_SIZE);

      gen_first  = 1'b0;
      gen_second = 1'b0;
      if (size >= CORNER_COUNT_BITS'(3)) begin
         if (is_hex) begin
            gen_first  = (pos == CORNER_COUNT_BITS'(2)) || (pos == CORNER_COUNT_BITS'(3)) ||
                         (pos == CORNER_COUNT_BITS'(5));
            gen_second = (pos == CORNER_COUNT_BITS'(5));
         end else begin
            gen_first  = (pos >= CORNER_COUNT_BITS'(2));
         end
      end

      tri_first.triangle_number = count_base;
      tri_first.corner_a        = VERTEX_FIELD_BITS'(anchor);
      tri_first.corner_b        = VERTEX_FIELD_BITS'(gen_second ? hex3_ff : prev_ff);
      tri_first.corner_c        = VERTEX_FIELD_BITS'(vert);
      tri_first.run_end         = !gen_second;

      tri_second.triangle_number = count_base + TRI_NUM_BITS'(1);
      tri_second.corner_a        = VERTEX_FIELD_BITS'(vert);
      tri_second.corner_b        = VERTEX_FIELD_BITS'(hex3_ff);
      tri_second.corner_c        = VERTEX_FIELD_BITS'(prev_ff);
      tri_second.run_end         = 1'b1;

      pos_inc = pos + CORNER_COUNT_BITS'(1);

      pos_in    = pos_ff;
      size_in   = size_ff;
      anchor_in = anchor_ff;
      prev_in   = prev_ff;
      hex3_in   = hex3_ff;
      count_in  = count_ff;
      if (accept) begin
         pos_in    = (pos_inc >= size || pos_inc == '0) ? '0 : pos_inc;
         size_in   = size;
         anchor_in = anchor;
         prev_in   = vert;
         if (is_hex && pos == CORNER_COUNT_BITS'(3)) begin
            hex3_in = vert;
         end
         count_in  = count_base + TRI_NUM_BITS'(gen_first) + TRI_NUM_BITS'(gen_second);
      end
   end

   always_comb begin
      logic [QUEUE_CNT_BITS-1:0] pushed;
      pushed    = accept ? (QUEUE_CNT_BITS'(gen_first) + QUEUE_CNT_BITS'(gen_second)) : '0;
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(pushed);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
      fill_in   = fill_ff + pushed - QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         size_ff   <= '0;
         anchor_ff <= '0;
         prev_ff   <= '0;
         hex3_ff   <= '0;
         count_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         pos_ff    <= pos_in;
         size_ff   <= size_in;
         anchor_ff <= anchor_in;
         prev_ff   <= prev_in;
         hex3_ff   <= hex3_in;
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue payload, no reset
   always_ff @(posedge clock) begin
      if (accept && gen_first) begin
         queue_ff[wr_ptr_ff] <= tri_first;
      end
      if (accept && gen_second) begin
         queue_ff[wr_ptr_ff + QUEUE_PTR_BITS'(1)] <= tri_second;
      end
   end

   assign rsp_chan.valid           = (fill_ff != '0);
   assign rsp_chan.triangle_number = queue_ff[rd_ptr_ff].triangle_number;
   assign rsp_chan.corner_a        = queue_ff[rd_ptr_ff].corner_a;
   assign rsp_chan.corner_b        = queue_ff[rd_ptr_ff].corner_b;
   assign rsp_chan.corner_c        = queue_ff[rd_ptr_ff].corner_c;
   assign rsp_chan.run_end         = queue_ff[rd_ptr_ff].run_end;

endmodule
